### hdl/sucl_pkg.sv
package sucl_pkg;

  localparam int FRAME_BYTES_DEF = 13;
  localparam int REPLY_BYTES     = 4;
  localparam int ENABLE_LEN      = 6;
  localparam int MOVE_LEN        = 13;

  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 144;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [7:0] SUFFIX_BYTE   = 8'h6B;
  localparam logic [7:0] OP_ENABLE     = 8'hF3;
  localparam logic [7:0] OP_MOVE       = 8'hFD;
  localparam logic [7:0] ENABLE_KEY    = 8'hAB;
  localparam logic [7:0] CODE_ACCEPTED = 8'h02;
  localparam logic [7:0] CODE_REACHED  = 8'h9F;
  localparam logic [7:0] CODE_FAULT_A  = 8'hE2;
  localparam logic [7:0] CODE_FAULT_B  = 8'hEE;

  localparam logic [7:0] NODE_ADDR_RST = 8'h01;
  localparam logic [7:0] TIMEOUT_RST   = 8'd20;

  typedef enum logic [1:0] {
    REQ_ENABLE,
    REQ_MOVE,
    REQ_SERVICE,
    REQ_RX
  } req_e;

  typedef enum logic [2:0] {
    EV_ACCEPT,
    EV_BUSY,
    EV_IDLE,
    EV_TX,
    EV_DONE,
    EV_TIMEOUT,
    EV_RXPEND,
    EV_REPLY
  } ev_e;

  typedef enum logic [2:0] {
    RSP_NONE,
    RSP_ACCEPTED,
    RSP_REACHED,
    RSP_PROTECT,
    RSP_PROTOCOL
  } rsp_e;

  typedef enum logic [0:0] {
    REG_NODE_ADDR,
    REG_TIMEOUT
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TX,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_REJECT,
    OP_BUILD_EN,
    OP_BUILD_MV,
    OP_IDLE,
    OP_TIMEOUT,
    OP_WAIT,
    OP_SERVICE,
    OP_RX,
    OP_TX,
    OP_DONE
  } op_e;

  typedef struct packed {
    op_e  op;
    logic start_timer;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic pending;
    logic timer_on;
    logic timed_out;
    logic room_zero;
    logic burst_one;
    logic finish;
  } stat_t;

  function automatic rsp_e classify(input logic [7:0] b0, input logic [7:0] node,
                                    input logic [7:0] b2, input logic [7:0] b3);
    rsp_e r;
    if (b0 != node || b3 != SUFFIX_BYTE) begin
      r = RSP_PROTOCOL;
    end else begin
      case (b2) inside
        CODE_ACCEPTED:              r = RSP_ACCEPTED;
        CODE_REACHED:               r = RSP_REACHED;
        CODE_FAULT_A, CODE_FAULT_B: r = RSP_PROTECT;
        default:                    r = RSP_PROTOCOL;
      endcase
    end
    return r;
  endfunction

endpackage

### hdl/stepper_uart_command_link_core.sv
// Command link to a stepper driver.
// Slave stream: one transaction per item, tuser selects the kind (enable command, move
// command, transmit service, received byte), tdata carries the operands.
// Master stream: the result transactions of that item, tlast on the final one. Every
// result carries the four wrapping counters and the latest reply code.
// APB port: node address at 0x0, timeout in ms at 0x4; pready is tied high.
// Commands, idle services, timeouts and received bytes give one result that
// is registered in the cycle the item is taken. A service that sends n frame bytes
// first sets up the burst, then gives one byte per cycle from the frame register file
// while the output is not stalled, plus the frame-done result if the frame finishes.
// One item is worked on at a time; a new item is taken once the sequencer is idle and
// the output register is empty or being read in the same cycle.
// Receiver stall: the output register holds its result and the sequencer waits.
// Reset: no frame pending, timer stopped, reply gathering restarted, counters and
// reply code cleared, node address 1, timeout 20 ms.
module stepper_uart_command_link_core #(
  parameter int FRAME_BYTES = sucl_pkg::FRAME_BYTES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // enable_flag, direction, move_speed, acceleration, step_total, move_mode,
  // axis_sync, now_ms, fifo_space, rx_byte
  input  logic [sucl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // req_type
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // event_res, tx_data, reply_status, queued_count, completed_count, reject_count,
  // timeout_total
  output logic [sucl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sucl_pkg::PADDR_W-1:0]       paddr,
  input  logic [sucl_pkg::PDATA_W-1:0]       pwdata,
  output logic [sucl_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);
  import sucl_pkg::*;

  logic [7:0]  node_q, node_d, tmo_q, tmo_d;
  reg_e        reg_sel;
  cmd_t        cmd;
  stat_t       stat;
  ev_e         event_res;
  rsp_e        reply_status;
  logic [7:0]  tx_data;
  logic [31:0] queued_count, completed_count, reject_count, timeout_total;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[2]);

  always_comb begin
    node_d = node_q;
    tmo_d  = tmo_q;
    if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_NODE_ADDR: node_d = pwdata[7:0];
        REG_TIMEOUT:   tmo_d  = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_NODE_ADDR: prdata = {24'd0, node_q};
      REG_TIMEOUT:   prdata = {24'd0, tmo_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q <= NODE_ADDR_RST;
      tmo_q  <= TIMEOUT_RST;
    end else begin
      node_q <= node_d;
      tmo_q  <= tmo_d;
    end
  end

  sucl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .req_i      (req_e'(s_axis_tuser)),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sucl_dp #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .node_addr_i       (node_q),
    .timeout_ms_i      (tmo_q),
    .enable_flag_i     (s_axis_tdata[0]),
    .direction_i       (s_axis_tdata[8:1]),
    .move_speed_i      (s_axis_tdata[24:9]),
    .acceleration_i    (s_axis_tdata[32:25]),
    .step_total_i      (s_axis_tdata[64:33]),
    .move_mode_i       (s_axis_tdata[72:65]),
    .axis_sync_i       (s_axis_tdata[80:73]),
    .now_ms_i          (s_axis_tdata[112:81]),
    .fifo_space_i      (s_axis_tdata[116:113]),
    .rx_byte_i         (s_axis_tdata[124:117]),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .event_res_o       (event_res),
    .tx_data_o         (tx_data),
    .last_o            (m_axis_tlast),
    .reply_status_o    (reply_status),
    .queued_count_o    (queued_count),
    .completed_count_o (completed_count),
    .reject_count_o    (reject_count),
    .timeout_total_o   (timeout_total)
  );

  assign m_axis_tdata = {2'b00, timeout_total, reject_count, completed_count, queued_count,
                         reply_status, tx_data, event_res};

endmodule

### hdl/sucl_ctrl.sv
module sucl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sucl_pkg::req_e  req_i,
  input  sucl_pkg::stat_t stat_i,
  output sucl_pkg::cmd_t  cmd_o
);
  import sucl_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE) && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && req_i == REQ_SERVICE && stat_i.pending && !stat_i.timed_out &&
            !stat_i.room_zero) begin
          state_d = ST_TX;
        end
      end
      ST_TX: begin
        if (stat_i.out_free && stat_i.burst_one) begin
          state_d = stat_i.finish ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op          = OP_NONE;
    cmd_o.start_timer = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i)
            REQ_ENABLE: cmd_o.op = stat_i.pending ? OP_REJECT : OP_BUILD_EN;
            REQ_MOVE:   cmd_o.op = stat_i.pending ? OP_REJECT : OP_BUILD_MV;
            REQ_SERVICE: begin
              if (!stat_i.pending) begin
                cmd_o.op = OP_IDLE;
              end else if (stat_i.timed_out) begin
                cmd_o.op = OP_TIMEOUT;
              end else begin
                cmd_o.op          = stat_i.room_zero ? OP_WAIT : OP_SERVICE;
                cmd_o.start_timer = !stat_i.timer_on;
              end
            end
            REQ_RX:     cmd_o.op = OP_RX;
            default:    cmd_o.op = OP_NONE;
          endcase
        end
      end
      ST_TX: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_TX;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_DONE;
        end
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/sucl_dp.sv
module sucl_dp #(
  parameter int FRAME_BYTES = sucl_pkg::FRAME_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sucl_pkg::cmd_t  cmd_i,
  output sucl_pkg::stat_t stat_o,
  input  logic [7:0]      node_addr_i,
  input  logic [7:0]      timeout_ms_i,
  input  logic            enable_flag_i,
  input  logic [7:0]      direction_i,
  input  logic [15:0]     move_speed_i,
  input  logic [7:0]      acceleration_i,
  input  logic [31:0]     step_total_i,
  input  logic [7:0]      move_mode_i,
  input  logic [7:0]      axis_sync_i,
  input  logic [31:0]     now_ms_i,
  input  logic [3:0]      fifo_space_i,
  input  logic [7:0]      rx_byte_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sucl_pkg::ev_e   event_res_o,
  output logic [7:0]      tx_data_o,
  output logic            last_o,
  output sucl_pkg::rsp_e  reply_status_o,
  output logic [31:0]     queued_count_o,
  output logic [31:0]     completed_count_o,
  output logic [31:0]     reject_count_o,
  output logic [31:0]     timeout_total_o
);
  import sucl_pkg::*;

  localparam int POS_W = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam int RX_N  = REPLY_BYTES - 1;

  logic [7:0]       frame_q [FRAME_BYTES];
  logic [7:0]       frame_d [FRAME_BYTES];
  logic [7:0]       rx_q [RX_N];
  logic [7:0]       rx_d [RX_N];
  logic [POS_W-1:0] len_q, len_d, pos_q, pos_d, burst_q, burst_d;
  logic             fin_q, fin_d, timer_q, timer_d;
  logic [31:0]      start_q, start_d;
  logic [1:0]       fill_q, fill_d;
  rsp_e             rsp_q, rsp_d;
  logic [31:0]      queued_q, queued_d, done_q, done_d, rej_q, rej_d, tmo_q, tmo_d;
  logic             ov_q, ov_d, olast_q, olast_d;
  ev_e              oev_q, oev_d;
  logic [7:0]       otx_q, otx_d;

  logic [31:0]      elapsed;
  logic             timed_out;
  logic [POS_W-1:0] remain, room, k;
  logic             emit, emit_last;
  ev_e              emit_ev;
  logic [7:0]       emit_tx;

  assign elapsed   = now_ms_i - start_q;
  assign timed_out = timer_q && (elapsed >= {24'd0, timeout_ms_i});
  assign remain    = len_q - pos_q;
  assign room      = POS_W'(fifo_space_i);
  assign k         = (room < remain) ? room : remain;

  assign stat_o.out_free  = !ov_q || out_ready_i;
  assign stat_o.pending   = (len_q != '0);
  assign stat_o.timer_on  = timer_q;
  assign stat_o.timed_out = timed_out;
  assign stat_o.room_zero = (k == '0);
  assign stat_o.burst_one = (burst_q == POS_W'(1));
  assign stat_o.finish    = fin_q;

  always_comb begin
    frame_d   = frame_q;
    rx_d      = rx_q;
    len_d     = len_q;
    pos_d     = pos_q;
    burst_d   = burst_q;
    fin_d     = fin_q;
    timer_d   = timer_q;
    start_d   = start_q;
    fill_d    = fill_q;
    rsp_d     = rsp_q;
    queued_d  = queued_q;
    done_d    = done_q;
    rej_d     = rej_q;
    tmo_d     = tmo_q;
    emit      = 1'b0;
    emit_last = 1'b1;
    emit_ev   = EV_IDLE;
    emit_tx   = 8'd0;

    case (cmd_i.op)
      OP_REJECT: begin
        rej_d   = rej_q + 32'd1;
        emit    = 1'b1;
        emit_ev = EV_BUSY;
      end
      OP_BUILD_EN: begin
        frame_d[0] = node_addr_i;
        frame_d[1] = OP_ENABLE;
        frame_d[2] = ENABLE_KEY;
        frame_d[3] = {7'd0, enable_flag_i};
        frame_d[4] = 8'd0;
        frame_d[5] = SUFFIX_BYTE;
        len_d      = POS_W'(ENABLE_LEN);
        pos_d      = '0;
        timer_d    = 1'b0;
        queued_d   = queued_q + 32'd1;
        emit       = 1'b1;
        emit_ev    = EV_ACCEPT;
      end
      OP_BUILD_MV: begin
        frame_d[0]  = node_addr_i;
        frame_d[1]  = OP_MOVE;
        frame_d[2]  = direction_i;
        frame_d[3]  = move_speed_i[15:8];
        frame_d[4]  = move_speed_i[7:0];
        frame_d[5]  = acceleration_i;
        frame_d[6]  = step_total_i[31:24];
        frame_d[7]  = step_total_i[23:16];
        frame_d[8]  = step_total_i[15:8];
        frame_d[9]  = step_total_i[7:0];
        frame_d[10] = move_mode_i;
        frame_d[11] = axis_sync_i;
        frame_d[12] = SUFFIX_BYTE;
        len_d       = POS_W'(MOVE_LEN);
        pos_d       = '0;
        timer_d     = 1'b0;
        queued_d    = queued_q + 32'd1;
        emit        = 1'b1;
        emit_ev     = EV_ACCEPT;
      end
      OP_IDLE, OP_WAIT: begin
        emit    = 1'b1;
        emit_ev = EV_IDLE;
      end
      OP_TIMEOUT: begin
        len_d   = '0;
        pos_d   = '0;
        timer_d = 1'b0;
        tmo_d   = tmo_q + 32'd1;
        emit    = 1'b1;
        emit_ev = EV_TIMEOUT;
      end
      OP_SERVICE: begin
        burst_d = k;
        fin_d   = (k == remain);
        if (k == remain) begin
          done_d = done_q + 32'd1;
        end
      end
      OP_RX: begin
        emit = 1'b1;
        if (fill_q == 2'(RX_N)) begin
          rsp_d   = classify(rx_q[0], node_addr_i, rx_q[2], rx_byte_i);
          fill_d  = 2'd0;
          emit_ev = EV_REPLY;
        end else begin
          rx_d[fill_q] = rx_byte_i;
          fill_d       = fill_q + 2'd1;
          emit_ev      = EV_RXPEND;
        end
      end
      OP_TX: begin
        emit      = 1'b1;
        emit_ev   = EV_TX;
        emit_tx   = frame_q[pos_q[IDX_W-1:0]];
        emit_last = (burst_q == POS_W'(1)) && !fin_q;
        pos_d     = pos_q + POS_W'(1);
        burst_d   = burst_q - POS_W'(1);
      end
      OP_DONE: begin
        len_d   = '0;
        pos_d   = '0;
        timer_d = 1'b0;
        emit    = 1'b1;
        emit_ev = EV_DONE;
      end
      default: ;
    endcase

    if (cmd_i.start_timer) begin
      timer_d = 1'b1;
      start_d = now_ms_i;
    end

    ov_d    = ov_q && !out_ready_i;
    oev_d   = oev_q;
    otx_d   = otx_q;
    olast_d = olast_q;
    if (emit) begin
      ov_d    = 1'b1;
      oev_d   = emit_ev;
      otx_d   = emit_tx;
      olast_d = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      pos_q    <= '0;
      burst_q  <= '0;
      fin_q    <= 1'b0;
      timer_q  <= 1'b0;
      start_q  <= 32'd0;
      fill_q   <= 2'd0;
      rsp_q    <= RSP_NONE;
      queued_q <= 32'd0;
      done_q   <= 32'd0;
      rej_q    <= 32'd0;
      tmo_q    <= 32'd0;
      ov_q     <= 1'b0;
    end else begin
      len_q    <= len_d;
      pos_q    <= pos_d;
      burst_q  <= burst_d;
      fin_q    <= fin_d;
      timer_q  <= timer_d;
      start_q  <= start_d;
      fill_q   <= fill_d;
      rsp_q    <= rsp_d;
      queued_q <= queued_d;
      done_q   <= done_d;
      rej_q    <= rej_d;
      tmo_q    <= tmo_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    rx_q    <= rx_d;
    oev_q   <= oev_d;
    otx_q   <= otx_d;
    olast_q <= olast_d;
  end

  // counters and reply code only change when an item is taken, before its first result
  assign out_valid_o       = ov_q;
  assign event_res_o       = oev_q;
  assign tx_data_o         = otx_q;
  assign last_o            = olast_q;
  assign reply_status_o    = rsp_q;
  assign queued_count_o    = queued_q;
  assign completed_count_o = done_q;
  assign reject_count_o    = rej_q;
  assign timeout_total_o   = tmo_q;

endmodule

### hdl/sucl_checker.sv
module sucl_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [sucl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);
  import sucl_pkg::*;

  logic is_tx;
  assign is_tx = (m_axis_tdata[2:0] == EV_TX);

  a_ready_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
    else $error("input taken while output register is blocked");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !is_tx |-> m_axis_tlast)
    else $error("non-byte result without tlast");

  a_tx_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !is_tx |-> (m_axis_tdata[10:3] == 8'd0))
    else $error("tx_data set on non-byte result");

endmodule

bind stepper_uart_command_link_core sucl_checker u_sucl_checker (.*);

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sucl_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int ITEMS_PER_SET  = 58;
  localparam int NUM_SETTINGS   = 5;
  localparam int DIR_ROWS       = 24;

  // s_axis_tdata layout, low bit first: enable_flag, direction, move_speed, acceleration,
  // step_total, move_mode, axis_sync, now_ms, fifo_space, rx_byte
  typedef struct packed {
    logic [2:0]  pad;
    logic [7:0]  rx_byte;
    logic [3:0]  fifo_space;
    logic [31:0] now_ms;
    logic [7:0]  axis_sync;
    logic [7:0]  move_mode;
    logic [31:0] step_total;
    logic [7:0]  acceleration;
    logic [15:0] move_speed;
    logic [7:0]  direction;
    logic        enable_flag;
  } link_req_t;

  // m_axis_tdata layout, low bit first: event_res, tx_data, reply_status, queued_count,
  // completed_count, reject_count, timeout_total
  typedef struct packed {
    logic [1:0]  pad;
    logic [31:0] timeout_total;
    logic [31:0] reject_count;
    logic [31:0] completed_count;
    logic [31:0] queued_count;
    rsp_e        reply_status;
    logic [7:0]  tx_data;
    ev_e         event_res;
  } link_res_t;

  typedef struct packed {
    logic      last;
    link_res_t res;
  } link_beat_t;

  typedef struct {
    req_e      kind;
    link_req_t req;
    bit        typed;
    ev_e       ev;
    rsp_e      rsp;
  } dir_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
  logic [1:0]              s_axis_tuser = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    m_axis_tlast;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PADDR_W-1:0]      paddr = '0;
  logic [PDATA_W-1:0]      pwdata = '0;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;

  stepper_uart_command_link_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk_i = ~clk_i;

  // link state mirror
  logic [7:0]  node_addr = NODE_ADDR_RST;
  logic [7:0]  timeout_lim = TIMEOUT_RST;
  logic [7:0]  frame_mem [0:FRAME_BYTES_DEF-1];
  logic [3:0]  frame_len = '0;
  logic [3:0]  send_pos = '0;
  bit          timer_on = 1'b0;
  logic [31:0] t_start = '0;
  logic [7:0]  rx_group [0:REPLY_BYTES-1];
  int          rx_fill = 0;
  rsp_e        reply_code = RSP_NONE;
  logic [31:0] n_queued = '0;
  logic [31:0] n_done = '0;
  logic [31:0] n_reject = '0;
  logic [31:0] n_timeout = '0;

  link_beat_t  link_results_q[$];
  logic [7:0]  reply_bytes_q[$];
  logic [31:0] ms_clock = 32'd1000;
  bit          idle_en = 1'b1;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  int          mismatches = 0;
  int          beats_seen = 0;
  int          items_sent = 0;

  task automatic compute_link_results(input req_e kind, input link_req_t rq);
    ev_e        evs[$];
    logic [7:0] txs[$];
    logic [3:0] room;
    link_beat_t b;
    case (kind)
      REQ_ENABLE, REQ_MOVE: begin
        if (frame_len != 0) begin
          n_reject++;
          evs.push_back(EV_BUSY);
          txs.push_back(8'h00);
        end else begin
          frame_mem[0] = node_addr;
          if (kind == REQ_ENABLE) begin
            frame_mem[1] = OP_ENABLE;
            frame_mem[2] = ENABLE_KEY;
            frame_mem[3] = {7'd0, rq.enable_flag};
            frame_mem[4] = 8'h00;
            frame_mem[5] = SUFFIX_BYTE;
            frame_len = 4'(ENABLE_LEN);
          end else begin
            frame_mem[1]  = OP_MOVE;
            frame_mem[2]  = rq.direction;
            frame_mem[3]  = rq.move_speed[15:8];
            frame_mem[4]  = rq.move_speed[7:0];
            frame_mem[5]  = rq.acceleration;
            frame_mem[6]  = rq.step_total[31:24];
            frame_mem[7]  = rq.step_total[23:16];
            frame_mem[8]  = rq.step_total[15:8];
            frame_mem[9]  = rq.step_total[7:0];
            frame_mem[10] = rq.move_mode;
            frame_mem[11] = rq.axis_sync;
            frame_mem[12] = SUFFIX_BYTE;
            frame_len = 4'(MOVE_LEN);
          end
          send_pos = '0;
          timer_on = 1'b0;
          n_queued++;
          evs.push_back(EV_ACCEPT);
          txs.push_back(8'h00);
        end
      end
      REQ_SERVICE: begin
        room = rq.fifo_space;
        if (frame_len == 0) begin
          evs.push_back(EV_IDLE);
          txs.push_back(8'h00);
        end else if (timer_on && (rq.now_ms - t_start) >= {24'd0, timeout_lim}) begin
          frame_len = '0;
          send_pos = '0;
          timer_on = 1'b0;
          n_timeout++;
          evs.push_back(EV_TIMEOUT);
          txs.push_back(8'h00);
        end else begin
          if (!timer_on) begin
            t_start = rq.now_ms;
            timer_on = 1'b1;
          end
          while (send_pos < frame_len && room > 0) begin
            evs.push_back(EV_TX);
            txs.push_back(frame_mem[send_pos]);
            send_pos++;
            room--;
          end
          if (send_pos >= frame_len) begin
            frame_len = '0;
            send_pos = '0;
            timer_on = 1'b0;
            n_done++;
            evs.push_back(EV_DONE);
            txs.push_back(8'h00);
          end else if (evs.size() == 0) begin
            evs.push_back(EV_IDLE);
            txs.push_back(8'h00);
          end
        end
      end
      default: begin
        rx_group[rx_fill] = rq.rx_byte;
        rx_fill++;
        if (rx_fill < REPLY_BYTES) begin
          evs.push_back(EV_RXPEND);
        end else begin
          if (rx_group[0] != node_addr || rx_group[3] != SUFFIX_BYTE) begin
            reply_code = RSP_PROTOCOL;
          end else if (rx_group[2] == CODE_ACCEPTED) begin
            reply_code = RSP_ACCEPTED;
          end else if (rx_group[2] == CODE_REACHED) begin
            reply_code = RSP_REACHED;
          end else if (rx_group[2] == CODE_FAULT_A || rx_group[2] == CODE_FAULT_B) begin
            reply_code = RSP_PROTECT;
          end else begin
            reply_code = RSP_PROTOCOL;
          end
          rx_fill = 0;
          evs.push_back(EV_REPLY);
        end
        txs.push_back(8'h00);
      end
    endcase
    foreach (evs[k]) begin
      b = '0;
      b.last = (k == evs.size() - 1);
      b.res.event_res = evs[k];
      b.res.tx_data = txs[k];
      b.res.reply_status = reply_code;
      b.res.queued_count = n_queued;
      b.res.completed_count = n_done;
      b.res.reject_count = n_reject;
      b.res.timeout_total = n_timeout;
      link_results_q.push_back(b);
    end
  endtask

  // one transaction on the slave stream; the mirror is advanced at acceptance
  task automatic send_item(input req_e kind, input link_req_t rq, input bit typed,
                           input ev_e ev, input rsp_e rsp);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= rq;
    do @(posedge clk_i); while (!s_axis_tready);
    compute_link_results(kind, rq);
    if (typed) begin
      link_results_q[link_results_q.size() - 1].res.event_res = ev;
      link_results_q[link_results_q.size() - 1].res.reply_status = rsp;
    end
    items_sent++;
  endtask

  task automatic apb_write(input reg_e idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_NODE_ADDR) node_addr = val;
    else timeout_lim = val;
  endtask

  task automatic set_regs(input logic [7:0] node, input logic [7:0] tmo);
    s_axis_tvalid <= 1'b0;
    while (link_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    apb_write(REG_NODE_ADDR, node);
    apb_write(REG_TIMEOUT, tmo);
  endtask

  function automatic dir_row_t row(input req_e kind, input link_req_t rq);
    dir_row_t r;
    r.kind = kind;
    r.req = rq;
    r.typed = 1'b0;
    r.ev = EV_ACCEPT;
    r.rsp = RSP_NONE;
    return r;
  endfunction

  function automatic dir_row_t typed_row(input dir_row_t r, input ev_e ev, input rsp_e rsp);
    r.typed = 1'b1;
    r.ev = ev;
    r.rsp = rsp;
    return r;
  endfunction

  function automatic link_req_t svc(input logic [31:0] now, input logic [3:0] space);
    link_req_t rq = '0;
    rq.now_ms = now;
    rq.fifo_space = space;
    return rq;
  endfunction

  function automatic link_req_t rxb(input logic [7:0] v);
    link_req_t rq = '0;
    rq.rx_byte = v;
    return rq;
  endfunction

  function automatic link_req_t move_req(input logic [7:0] v8, input logic [15:0] v16,
                                         input logic [31:0] v32);
    link_req_t rq = '0;
    rq.direction = v8;
    rq.move_speed = v16;
    rq.acceleration = v8;
    rq.step_total = v32;
    rq.move_mode = v8;
    rq.axis_sync = v8;
    return rq;
  endfunction

  function automatic link_req_t en_req(input logic flag);
    link_req_t rq = '0;
    rq.enable_flag = flag;
    return rq;
  endfunction

  task automatic random_item(output req_e kind, output link_req_t rq);
    int pick;
    int code_pick;
    rq = {$urandom, $urandom, $urandom, $urandom};
    rq.pad = '0;
    rq.fifo_space = 4'($urandom_range(0, 13));
    pick = $urandom_range(0, 99);
    if (frame_len != 0) begin
      kind = (pick < 65) ? REQ_SERVICE : (pick < 75) ? req_e'($urandom_range(0, 1)) : REQ_RX;
    end else begin
      kind = (pick < 40) ? req_e'($urandom_range(0, 1)) : (pick < 55) ? REQ_SERVICE : REQ_RX;
    end
    if (kind == REQ_SERVICE) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) ms_clock += $urandom_range(0, 3);
      else if (pick < 96) ms_clock += $urandom_range(0, 300);
      else ms_clock = $urandom;
      rq.now_ms = ms_clock;
    end else if (kind == REQ_RX) begin
      if (reply_bytes_q.size() == 0) begin
        if (rx_fill == 0 && $urandom_range(0, 4) != 0) begin
          code_pick = $urandom_range(0, 4);
          reply_bytes_q.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : node_addr);
          reply_bytes_q.push_back(8'($urandom));
          case (code_pick)
            0: reply_bytes_q.push_back(CODE_ACCEPTED);
            1: reply_bytes_q.push_back(CODE_REACHED);
            2: reply_bytes_q.push_back(CODE_FAULT_A);
            3: reply_bytes_q.push_back(CODE_FAULT_B);
            default: reply_bytes_q.push_back(8'($urandom));
          endcase
          reply_bytes_q.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : SUFFIX_BYTE);
        end else begin
          reply_bytes_q.push_back(8'($urandom));
        end
      end
      rq.rx_byte = reply_bytes_q.pop_front();
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    link_beat_t got;
    link_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = link_beat_t'({m_axis_tlast, m_axis_tdata});
      beats_seen++;
      if (link_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", got);
      end else begin
        want = link_results_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch\n  exp: %p\n  act: %p", want, got);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL stepper_uart_command_link_core");
      $finish;
    end
  end

  initial begin
    dir_row_t   dir_tbl [DIR_ROWS];
    logic [7:0] node_set [NUM_SETTINGS];
    logic [7:0] tmo_set [NUM_SETTINGS];
    req_e       kind;
    link_req_t  rq;

    dir_tbl = '{
      typed_row(row(REQ_SERVICE, svc(32'd0, 4'd13)), EV_IDLE, RSP_NONE),
      row(REQ_RX, rxb(8'h01)),
      row(REQ_RX, rxb(8'h00)),
      row(REQ_RX, rxb(CODE_ACCEPTED)),
      typed_row(row(REQ_RX, rxb(SUFFIX_BYTE)), EV_REPLY, RSP_ACCEPTED),
      typed_row(row(REQ_ENABLE, en_req(1'b1)), EV_ACCEPT, RSP_ACCEPTED),
      typed_row(row(REQ_MOVE, move_req(8'hFF, 16'hFFFF, 32'hFFFF_FFFF)), EV_BUSY,
                RSP_ACCEPTED),
      typed_row(row(REQ_ENABLE, en_req(1'b0)), EV_BUSY, RSP_ACCEPTED),
      typed_row(row(REQ_SERVICE, svc(32'd100, 4'd0)), EV_IDLE, RSP_ACCEPTED),
      row(REQ_SERVICE, svc(32'd105, 4'd13)),
      typed_row(row(REQ_MOVE, move_req(8'hFF, 16'hFFFF, 32'hFFFF_FFFF)), EV_ACCEPT,
                RSP_ACCEPTED),
      row(REQ_SERVICE, svc(32'hFFFF_FFF8, 4'd1)),
      row(REQ_SERVICE, svc(32'h0000_0005, 4'd5)),
      typed_row(row(REQ_SERVICE, svc(32'h0000_000C, 4'd13)), EV_TIMEOUT, RSP_ACCEPTED),
      typed_row(row(REQ_MOVE, move_req(8'h00, 16'h0000, 32'h0000_0000)), EV_ACCEPT,
                RSP_ACCEPTED),
      row(REQ_SERVICE, svc(32'd200, 4'd13)),
      row(REQ_ENABLE, en_req(1'b0)),
      row(REQ_SERVICE, svc(32'd300, 4'd3)),
      row(REQ_SERVICE, svc(32'd319, 4'd13)),
      row(REQ_MOVE, move_req(8'hA5, 16'h8001, 32'h8000_0001)),
      row(REQ_RX, rxb(8'h02)),
      row(REQ_RX, rxb(8'hFF)),
      row(REQ_RX, rxb(CODE_ACCEPTED)),
      typed_row(row(REQ_RX, rxb(SUFFIX_BYTE)), EV_REPLY, RSP_PROTOCOL)
    };
    node_set = '{8'h00, 8'hFF, 8'h5A, 8'($urandom), 8'h01};
    tmo_set  = '{8'd1, 8'd255, 8'd0, 8'($urandom_range(1, 255)), 8'd20};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      send_item(dir_tbl[i].kind, dir_tbl[i].req, dir_tbl[i].typed, dir_tbl[i].ev,
                dir_tbl[i].rsp);
    end

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      set_regs(node_set[p], tmo_set[p]);
      idle_en = (p != NUM_SETTINGS - 1);
      repeat (ITEMS_PER_SET) begin
        random_item(kind, rq);
        send_item(kind, rq, 1'b0, EV_ACCEPT, RSP_NONE);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (link_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d items, %0d result transactions, %0d register settings",
             items_sent, beats_seen, NUM_SETTINGS);
    $display("frames queued %0d, done %0d, rejected %0d, timed out %0d; mismatches %0d",
             n_queued, n_done, n_reject, n_timeout, mismatches);
    if (mismatches == 0) begin
      $display("PASS stepper_uart_command_link_core");
    end else begin
      $display("FAIL stepper_uart_command_link_core");
    end
    $finish;
  end

endmodule

### sim.f
hdl/sucl_pkg.sv
hdl/sucl_ctrl.sv
hdl/sucl_dp.sv
hdl/stepper_uart_command_link_core.sv
hdl/sucl_checker.sv
dv/tb_top.sv
